// ===== sv/sensor_frame_deframer_top_assert.svh =====
// assertion macros for the sensor frame deframer
`ifndef SENSOR_FRAME_DEFRAMER_TOP_ASSERT_SVH
`define SENSOR_FRAME_DEFRAMER_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SFD_ASSERT_IMPLY(label, clock, reset, cond, prop) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
    else $error("sfd assertion failed");

// next-cycle implication, disabled in reset
`define SFD_ASSERT_NEXT(label, clock, reset, cond, prop) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
    else $error("sfd assertion failed");

`endif

// ===== sv/sfd_pkg.sv =====
package sfd_pkg;

  localparam int CAPTURE_BYTES_DEF = 14;
  localparam int NUM_TYPES = 6;
  localparam int ADDR_W = 5;

  localparam logic [7:0] HDR_FIRST = 8'hAA;
  localparam logic [7:0] HDR_SECOND = 8'h55;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [NUM_TYPES-1:0][7:0] TYPE_CODE_RESET =
    {8'd6, 8'd5, 8'd4, 8'd3, 8'd2, 8'd1};

  localparam logic [3:0] OC_SENSOR_BASE  = 4'd0;
  localparam logic [3:0] OC_SENSOR_SEQ   = 4'd1;
  localparam logic [3:0] OC_SENSOR_LIGHT = 4'd2;
  localparam logic [3:0] OC_ALARM        = 4'd3;
  localparam logic [3:0] OC_HEARTBEAT    = 4'd4;
  localparam logic [3:0] OC_CMD_ACK      = 4'd5;
  localparam logic [3:0] OC_STATUS       = 4'd6;
  localparam logic [3:0] OC_REPORT_ACK   = 4'd7;
  localparam logic [3:0] OC_UNKNOWN      = 4'd8;
  localparam logic [3:0] OC_SHORT        = 4'd9;
  localparam logic [3:0] OC_CRC_ERR      = 4'd10;

  typedef logic [NUM_TYPES-1:0][7:0] type_codes_t;

  typedef struct packed {
    logic [3:0]          outcome;
    logic [7:0]          node_id;
    logic signed [15:0]  temperature_tenths;
    logic [15:0]         humidity_tenths;
    logic [15:0]         voltage_millivolts;
    logic [15:0]         light_level;
    logic [7:0]          status_byte;
    logic [31:0]         sequence_res;
    logic [15:0]         ack_ident;
    logic [7:0]          ack_code;
    logic [15:0]         version_word;
  } frame_fields_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== sv/sensor_frame_deframer_top.sv =====
// sensor frame deframer
// rx channel (rx_valid, rx_stall, rx_byte) takes one received serial byte per request.
// the block hunts for the AA 55 header, reads length, type, payload and a
// little-endian CRC-16/MODBUS, and gives one result request on the res channel
// (res_valid, res_stall) for the last CRC byte of each frame; other bytes give none.
// throughput: one byte per clock cycle while rx_stall is low, set by the combinational
// byte-wide CRC update and framing state update after the input register.
// the last CRC byte passes through the input register, and its result is loaded
// into the result register once that register is free.
// a stalled result holds in the result register while bytes keep flowing in;
// rx_stall rises only when the last CRC byte of the next frame meets a
// result that is still stalled.
// type codes are written through the configuration port, byte address 4*i, low 8 bits.
// synchronous reset restarts the header hunt, resets payload position and running CRC,
// clears the drop counter and both valid flags, and restores the type codes to 1 to 6.
`include "sensor_frame_deframer_top_assert.svh"

module sensor_frame_deframer_top #(
  parameter int CAPTURE_BYTES = sfd_pkg::CAPTURE_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rx_valid,
  output logic                       rx_stall,
  input  logic [7:0]                 rx_byte,
  output logic                       res_valid,
  input  logic                       res_stall,
  output logic [3:0]                 outcome,
  output logic [7:0]                 node_id,
  output logic signed [15:0]         temperature_tenths,
  output logic [15:0]                humidity_tenths,
  output logic [15:0]                voltage_millivolts,
  output logic [15:0]                light_level,
  output logic [7:0]                 status_byte,
  output logic [31:0]                sequence_res,
  output logic [15:0]                ack_ident,
  output logic [7:0]                 ack_code,
  output logic [15:0]                version_word,
  output logic [31:0]                dropped_total,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sfd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import sfd_pkg::*;

  localparam logic [2:0] PH_H1    = 3'd0;
  localparam logic [2:0] PH_H2    = 3'd1;
  localparam logic [2:0] PH_LEN   = 3'd2;
  localparam logic [2:0] PH_TYPE  = 3'd3;
  localparam logic [2:0] PH_PAY   = 3'd4;
  localparam logic [2:0] PH_CRCLO = 3'd5;
  localparam logic [2:0] PH_CRCHI = 3'd6;

  type_codes_t type_codes;
  logic [2:0]  cfg_index;

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        advance;

  logic [2:0]  phase, phase_next;
  logic [7:0]  frame_length, frame_length_next;
  logic [7:0]  frame_type_byte, frame_type_byte_next;
  logic [7:0]  payload_position, payload_position_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  crc_low_byte, crc_low_byte_next;
  logic [CAPTURE_BYTES-1:0][7:0] captured_payload, captured_payload_next;
  logic [31:0] dropped_count, dropped_next;
  logic [8:0]  drop_amount;
  logic [32:0] drop_sum;

  frame_fields_t fields;
  logic [8:0]    frame_drop;
  frame_fields_t res_fields;

  // configuration port
  assign pready = 1'b1;
  assign cfg_index = paddr[ADDR_W-1:2];

  always_comb begin
    prdata = '0;
    if (cfg_index < 3'(NUM_TYPES)) begin
      prdata = {24'h0, type_codes[cfg_index]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      type_codes <= TYPE_CODE_RESET;
    end else if (psel && penable && pwrite && pready && cfg_index < 3'(NUM_TYPES)) begin
      type_codes[cfg_index] <= pwdata[7:0];
    end
  end

  // input register, held back only when a result would meet a stalled one
  assign advance = in_valid && !(phase == PH_CRCHI && res_valid && res_stall);
  assign rx_stall = in_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!rx_stall) begin
      in_valid <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && !rx_stall) begin
      in_byte <= rx_byte;
    end
  end

  sfd_decode #(
    .CAPTURE_BYTES(CAPTURE_BYTES)
  ) u_decode (
    .frame_length    (frame_length),
    .frame_type_byte (frame_type_byte),
    .running_crc     (running_crc),
    .crc_low_byte    (crc_low_byte),
    .crc_high_byte   (in_byte),
    .type_codes      (type_codes),
    .payload         (captured_payload),
    .fields          (fields),
    .drop_amount     (frame_drop)
  );

  // framing state
  always_comb begin
    phase_next = phase;
    frame_length_next = frame_length;
    frame_type_byte_next = frame_type_byte;
    payload_position_next = payload_position;
    running_crc_next = running_crc;
    crc_low_byte_next = crc_low_byte;
    captured_payload_next = captured_payload;
    drop_amount = '0;
    case (phase)
      PH_H1: begin
        if (in_byte == HDR_FIRST) begin
          phase_next = PH_H2;
        end else begin
          drop_amount = 9'd1;
        end
      end
      PH_H2: begin
        if (in_byte == HDR_SECOND) begin
          phase_next = PH_LEN;
        end else if (in_byte == HDR_FIRST) begin
          drop_amount = 9'd1;
        end else begin
          drop_amount = 9'd2;
          phase_next = PH_H1;
        end
      end
      PH_LEN: begin
        if (in_byte == 8'h00) begin
          drop_amount = 9'd3;
          phase_next = PH_H1;
        end else begin
          frame_length_next = in_byte;
          running_crc_next = crc16_byte(CRC_INIT, in_byte);
          phase_next = PH_TYPE;
        end
      end
      PH_TYPE: begin
        frame_type_byte_next = in_byte;
        running_crc_next = crc16_byte(running_crc, in_byte);
        payload_position_next = '0;
        captured_payload_next = '0;
        phase_next = (frame_length == 8'd1) ? PH_CRCLO : PH_PAY;
      end
      PH_PAY: begin
        for (int i = 0; i < CAPTURE_BYTES; i++) begin
          if (payload_position == 8'(i)) begin
            captured_payload_next[i] = in_byte;
          end
        end
        running_crc_next = crc16_byte(running_crc, in_byte);
        payload_position_next = payload_position + 8'd1;
        if ({1'b0, payload_position_next} + 9'd1 >= {1'b0, frame_length}) begin
          phase_next = PH_CRCLO;
        end
      end
      PH_CRCLO: begin
        crc_low_byte_next = in_byte;
        phase_next = PH_CRCHI;
      end
      PH_CRCHI: begin
        drop_amount = frame_drop;
        phase_next = PH_H1;
      end
      default: begin
        phase_next = PH_H1;
      end
    endcase
  end

  // saturating drop counter
  assign drop_sum = {1'b0, dropped_count} + {24'h0, drop_amount};
  assign dropped_next = drop_sum[32] ? 32'hFFFF_FFFF : drop_sum[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_H1;
      payload_position <= '0;
      running_crc <= CRC_INIT;
      dropped_count <= '0;
    end else if (advance) begin
      phase <= phase_next;
      payload_position <= payload_position_next;
      running_crc <= running_crc_next;
      dropped_count <= dropped_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      frame_length <= frame_length_next;
      frame_type_byte <= frame_type_byte_next;
      crc_low_byte <= crc_low_byte_next;
      captured_payload <= captured_payload_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && phase == PH_CRCHI) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && phase == PH_CRCHI) begin
      res_fields <= fields;
      dropped_total <= dropped_next;
    end
  end

  assign outcome = res_fields.outcome;
  assign node_id = res_fields.node_id;
  assign temperature_tenths = res_fields.temperature_tenths;
  assign humidity_tenths = res_fields.humidity_tenths;
  assign voltage_millivolts = res_fields.voltage_millivolts;
  assign light_level = res_fields.light_level;
  assign status_byte = res_fields.status_byte;
  assign sequence_res = res_fields.sequence_res;
  assign ack_ident = res_fields.ack_ident;
  assign ack_code = res_fields.ack_code;
  assign version_word = res_fields.version_word;

  `SFD_ASSERT_NEXT(a_result_after_crc, clk, rst, advance && phase == PH_CRCHI,
    res_valid && phase == PH_H1)
  `SFD_ASSERT_IMPLY(a_drop_monotonic, clk, rst, !$past(rst),
    dropped_count >= $past(dropped_count))
  `SFD_ASSERT_IMPLY(a_payload_bound, clk, rst, phase == PH_PAY,
    {1'b0, payload_position} + 9'd1 < {1'b0, frame_length})

endmodule

// ===== sv/sfd_decode.sv =====
module sfd_decode #(
  parameter int CAPTURE_BYTES = sfd_pkg::CAPTURE_BYTES_DEF
) (
  input  logic [7:0]                      frame_length,
  input  logic [7:0]                      frame_type_byte,
  input  logic [15:0]                     running_crc,
  input  logic [7:0]                      crc_low_byte,
  input  logic [7:0]                      crc_high_byte,
  input  sfd_pkg::type_codes_t            type_codes,
  input  logic [CAPTURE_BYTES-1:0][7:0]   payload,
  output sfd_pkg::frame_fields_t          fields,
  output logic [8:0]                      drop_amount
);
  import sfd_pkg::*;

  localparam logic [2:0] KIND_SENSOR = 3'd0;
  localparam logic [2:0] KIND_ALARM  = 3'd1;
  localparam logic [2:0] KIND_HBEAT  = 3'd2;
  localparam logic [2:0] KIND_CMDACK = 3'd3;
  localparam logic [2:0] KIND_STATUS = 3'd4;
  localparam logic [2:0] KIND_REPACK = 3'd5;
  localparam logic [2:0] KIND_NONE   = 3'd6;

  logic [2:0] kind;
  logic [7:0] plen;
  logic       crc_ok;

  assign plen = frame_length - 8'd1;
  assign crc_ok = ({crc_high_byte, crc_low_byte} == running_crc);

  // first matching register wins
  always_comb begin
    kind = KIND_NONE;
    for (int i = NUM_TYPES - 1; i >= 0; i--) begin
      if (frame_type_byte == type_codes[i]) begin
        kind = 3'(i);
      end
    end
  end

  always_comb begin
    fields = '0;
    drop_amount = '0;
    if (!crc_ok) begin
      fields.outcome = OC_CRC_ERR;
      drop_amount = {1'b0, frame_length} + 9'd5;
    end else begin
      fields.outcome = OC_SHORT;
      case (kind)
        KIND_SENSOR: begin
          if (plen >= 8'd8) begin
            fields.node_id = payload[0];
            fields.temperature_tenths = $signed({payload[2], payload[1]});
            fields.humidity_tenths = {payload[4], payload[3]};
            fields.voltage_millivolts = {payload[6], payload[5]};
            if (plen >= 8'd14) begin
              fields.outcome = OC_SENSOR_LIGHT;
              fields.light_level = {payload[8], payload[7]};
              fields.status_byte = payload[9];
              fields.sequence_res = {payload[13], payload[12], payload[11], payload[10]};
            end else if (plen >= 8'd12) begin
              fields.outcome = OC_SENSOR_SEQ;
              fields.status_byte = payload[7];
              fields.sequence_res = {payload[11], payload[10], payload[9], payload[8]};
            end else begin
              fields.outcome = OC_SENSOR_BASE;
              fields.status_byte = payload[7];
            end
          end
        end
        KIND_ALARM: begin
          if (plen >= 8'd2) begin
            fields.outcome = OC_ALARM;
            fields.node_id = payload[0];
            fields.status_byte = payload[1];
          end
        end
        KIND_HBEAT: begin
          if (plen >= 8'd1) begin
            fields.outcome = OC_HEARTBEAT;
            fields.node_id = payload[0];
          end
        end
        KIND_CMDACK: begin
          if (plen >= 8'd4) begin
            fields.outcome = OC_CMD_ACK;
            fields.node_id = payload[0];
            fields.ack_ident = {payload[2], payload[1]};
            fields.ack_code = payload[3];
          end
        end
        KIND_STATUS: begin
          if (plen >= 8'd3) begin
            fields.outcome = OC_STATUS;
            fields.node_id = payload[0];
            fields.status_byte = payload[1];
            fields.version_word = {payload[2], (plen >= 8'd4) ? payload[3] : 8'h00};
          end
        end
        KIND_REPACK: begin
          fields.outcome = OC_REPORT_ACK;
        end
        default: begin
          fields.outcome = OC_UNKNOWN;
        end
      endcase
      if (fields.outcome == OC_REPORT_ACK || fields.outcome == OC_SHORT) begin
        drop_amount = {1'b0, plen};
      end
    end
  end

endmodule
